[src/shf32_pkg.sv]
// ============================================================================
// shf32_pkg: shared types for the 32-bit SuperFastHash engine
// Holds the round codes and the command record passed from front to back.
// ============================================================================
package shf32_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_ROUND = 3'd1,
      OP_TAIL1 = 3'd2,
      OP_TAIL2 = 3'd3,
      OP_TAIL3 = 3'd4
   } op_type;

   typedef struct packed {
      logic         first;
      logic         last;
      op_type       op;
      logic [30:0]  len;
      logic [31:0]  word;
   } cmd_type;

   localparam int CMD_W  = $bits(cmd_type);
   localparam int HASH_W = 32;

endpackage

[src/shf32_fifo.sv]
// ============================================================================
// shf32_fifo: small synchronous queue
// Register-based queue with a combinational head and an occupancy count.
// ============================================================================
module shf32_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   output logic                           full,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/shf32_front.sv]
// ============================================================================
// shf32_front: input classifier
// Tracks message boundaries and turns each word into a round command.
// ============================================================================
module shf32_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_valid_bytes,
   input  logic [30:0]           req_total_length,
   input  logic                  req_last,
   input  logic                  q_full,
   output logic                  q_push,
   output shf32_pkg::cmd_type    q_cmd
);

   logic in_message_ff, in_message_in;
   logic accept;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept;

   always_comb begin
      q_cmd.first = !in_message_ff;
      q_cmd.last  = req_last;
      q_cmd.len   = req_total_length;
      q_cmd.word  = req_data_word;
      q_cmd.op    = shf32_pkg::OP_NONE;
      priority if (req_valid_bytes >= 3'd4) begin
         q_cmd.op = shf32_pkg::OP_ROUND;
      end else if (req_last) begin
         unique case (req_valid_bytes[1:0])
            2'd1:    q_cmd.op = shf32_pkg::OP_TAIL1;
            2'd2:    q_cmd.op = shf32_pkg::OP_TAIL2;
            2'd3:    q_cmd.op = shf32_pkg::OP_TAIL3;
            default: q_cmd.op = shf32_pkg::OP_NONE;
         endcase
      end else begin
         q_cmd.op = shf32_pkg::OP_NONE;
      end
   end

   always_comb begin
      in_message_in = in_message_ff;
      if (accept) begin
         in_message_in = !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

[src/shf32_back.sv]
// ============================================================================
// shf32_back: hash datapath
// Applies one round per command and runs the final avalanche in two stages.
// ============================================================================
module shf32_back #(
   parameter int RESULT_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  shf32_pkg::cmd_type                q_cmd,
   output logic                              q_pop,
   input  logic [$clog2(RESULT_DEPTH+1)-1:0] res_count,
   output logic                              res_push,
   output logic [shf32_pkg::HASH_W-1:0]      res_data
);

   localparam int RC_W  = $clog2(RESULT_DEPTH+1);
   localparam int SUM_W = RC_W + 1;

   logic [31:0] hash_ff, hash_in;
   logic [31:0] s1_ff, s1_in;
   logic [31:0] s2_ff, s2_in;
   logic        v1_ff, v1_in;
   logic        v2_ff, v2_in;
   logic [31:0] h_base, h_mix;
   logic        credit_ok;
   logic        go;

   function automatic logic [31:0] sext8(input logic [7:0] b);
      sext8 = {{24{b[7]}}, b};
   endfunction

   function automatic logic [31:0] word_round(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] a, t, b;
      a = h + {16'd0, w[15:0]};
      t = ({16'd0, w[31:16]} << 11) ^ a;
      b = (a << 16) ^ t;
      word_round = b + (b >> 11);
   endfunction

   function automatic logic [31:0] tail_mix(input logic [31:0] h, input logic [31:0] w,
                                            input shf32_pkg::op_type op);
      logic [31:0] a, b, c;
      a = '0;
      b = '0;
      c = h;
      unique case (op)
         shf32_pkg::OP_TAIL3: begin
            a = h + {16'd0, w[15:0]};
            b = a ^ (a << 16);
            b = b ^ (sext8(w[23:16]) << 18);
            c = b + (b >> 11);
         end
         shf32_pkg::OP_TAIL2: begin
            a = h + {16'd0, w[15:0]};
            b = a ^ (a << 11);
            c = b + (b >> 17);
         end
         shf32_pkg::OP_TAIL1: begin
            a = h + sext8(w[7:0]);
            b = a ^ (a << 10);
            c = b + (b >> 1);
         end
         shf32_pkg::OP_ROUND: c = word_round(h, w);
         default:             c = h;
      endcase
      tail_mix = c;
   endfunction

   function automatic logic [31:0] aval_a(input logic [31:0] h);
      logic [31:0] a, b;
      a = h ^ (h << 3);
      b = a + (a >> 5);
      aval_a = b ^ (b << 4);
   endfunction

   function automatic logic [31:0] aval_b(input logic [31:0] h);
      logic [31:0] a, b;
      a = h + (h >> 17);
      b = a ^ (a << 25);
      aval_b = b + (b >> 6);
   endfunction

   assign credit_ok = (SUM_W'(res_count) + SUM_W'(v1_ff) + SUM_W'(v2_ff))
                      < SUM_W'(RESULT_DEPTH);
   assign go        = !q_empty && (!q_cmd.last || credit_ok);
   assign q_pop     = go;
   assign h_base    = q_cmd.first ? {1'b0, q_cmd.len} : hash_ff;
   assign h_mix     = tail_mix(h_base, q_cmd.word, q_cmd.op);

   always_comb begin
      hash_in = hash_ff;
      s1_in   = s1_ff;
      if (go) begin
         hash_in = q_cmd.last ? '0 : h_mix;
         s1_in   = h_mix;
      end
      v1_in = go && q_cmd.last;
      v2_in = v1_ff;
      s2_in = aval_a(s1_ff);
   end

   assign res_push = v2_ff;
   assign res_data = aval_b(s2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

[src/superfasthash_32.sv]
// ============================================================================
// superfasthash_32: streaming 32-bit SuperFastHash engine
// Hashes byte messages sent as little-endian words and queues the results.
// ============================================================================
// Usage:
//  Input side is a queue: drive req_* and push; the transaction is taken
//  when push is high and full is low. One word per transaction, four bytes
//  except on the transaction marked req_last, which carries 0 to 4 bytes.
//  req_total_length is sampled on the first word of each message.
//  Result side is a queue: rsp_hash_value holds the oldest hash while empty
//  is low; pop it with pop high and empty low. One hash per message.
//  Throughput: one word per cycle unless the result side stalls, set by the
//  round on the running hash register in the back end.
//  A hash shows on the result side after its last word is taken and passes
//  the command queue, the round, the first avalanche stage and the second stage into the result queue.
//  A stalled result side fills the result queue; the back end then holds
//  last words in the command queue, which fills and raises full.
//  Reset empties both queues and clears the running hash and message state.
// ============================================================================
module superfasthash_32 #(
   parameter int QUEUE_DEPTH  = 4,
   parameter int RESULT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic [30:0] req_total_length,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_hash_value
);

   localparam int RC_W = $clog2(RESULT_DEPTH+1);

   shf32_pkg::cmd_type               f_cmd;
   shf32_pkg::cmd_type               b_cmd;
   logic                             q_push, q_full, q_pop, q_empty;
   logic [shf32_pkg::CMD_W-1:0]      q_data;
   logic                             res_push, res_full;
   logic [shf32_pkg::HASH_W-1:0]     res_data;
   logic [RC_W-1:0]                  res_count;

   shf32_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_last         (req_last),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (f_cmd)
   );

   shf32_fifo #(
      .WIDTH (shf32_pkg::CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (f_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .count     ()
   );

   assign b_cmd = shf32_pkg::cmd_type'(q_data);

   shf32_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (b_cmd),
      .q_pop     (q_pop),
      .res_count (res_count),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   shf32_fifo #(
      .WIDTH (shf32_pkg::HASH_W),
      .DEPTH (RESULT_DEPTH)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_hash_value),
      .empty     (empty),
      .count     (res_count)
   );

`ifndef SYNTHESIS
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into full result queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty command queue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");
`endif

endmodule

[dv/superfasthash_32_check.sv]
`timescale 1ns / 1ps
// ============================================================================
// superfasthash_32_check: hash predictor and scoreboard
// Watches both queue ports of the hash engine, rebuilds each message hash
// from the accepted words and compares every popped hash with the oldest one.
// ============================================================================
module superfasthash_32_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic [30:0] req_total_length,
   input  logic        req_last,
   input  logic        empty,
   input  logic        pop,
   input  logic [31:0] rsp_hash_value,
   output int          fail_count,
   output int          expect_count
);

   bit [31:0]          msg_hash;
   bit                 msg_open;
   bit [31:0]          hash_queue[$];
   bit [31:0]          want_hash;
   shf32_pkg::op_type  word_op;

   function automatic shf32_pkg::op_type classify(logic [2:0] nbytes, logic last_flag);
      if (nbytes >= 3'd4) return shf32_pkg::OP_ROUND;
      if (!last_flag) return shf32_pkg::OP_NONE;
      case (nbytes)
         3'd3: return shf32_pkg::OP_TAIL3;
         3'd2: return shf32_pkg::OP_TAIL2;
         3'd1: return shf32_pkg::OP_TAIL1;
         default: return shf32_pkg::OP_NONE;
      endcase
   endfunction

   function automatic bit [31:0] word_mix(bit [31:0] h, bit [31:0] w);
      bit [31:0] t;
      h = h + w[15:0];
      t = (32'(w[31:16]) << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   function automatic bit [31:0] tail_mix(bit [31:0] h, bit [31:0] w,
                                          shf32_pkg::op_type op);
      case (op)
         shf32_pkg::OP_TAIL3: begin
            h = h + w[15:0];
            h = h ^ (h << 16);
            h = h ^ ({{24{w[23]}}, w[23:16]} << 18);
            h = h + (h >> 11);
         end
         shf32_pkg::OP_TAIL2: begin
            h = h + w[15:0];
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         shf32_pkg::OP_TAIL1: begin
            h = h + {{24{w[7]}}, w[7:0]};
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: ;
      endcase
      return h;
   endfunction

   function automatic bit [31:0] avalanche(bit [31:0] h);
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      fail_count++;
   endtask

   initial begin
      fail_count   = 0;
      expect_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         msg_hash = '0;
         msg_open = 1'b0;
         hash_queue.delete();
      end else begin
         if (pop && !empty) begin
            if (hash_queue.size() == 0) begin
               report_error($sformatf("hash %08h popped with no message pending",
                                      rsp_hash_value));
            end else begin
               want_hash = hash_queue.pop_front();
               if (rsp_hash_value !== want_hash)
                  report_error($sformatf("hash_value expected %08h, got %08h",
                                         want_hash, rsp_hash_value));
            end
         end
         if (push && !full) begin
            if (!msg_open) begin
               msg_hash = {1'b0, req_total_length};
               msg_open = 1'b1;
            end
            word_op = classify(req_valid_bytes, req_last);
            if (word_op == shf32_pkg::OP_ROUND)
               msg_hash = word_mix(msg_hash, req_data_word);
            else if (word_op != shf32_pkg::OP_NONE)
               msg_hash = tail_mix(msg_hash, req_data_word, word_op);
            if (req_last) begin
               hash_queue.push_back(avalanche(msg_hash));
               msg_hash = '0;
               msg_open = 1'b0;
            end
         end
      end
      expect_count = hash_queue.size();
   end

endmodule

[dv/superfasthash_32_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// superfasthash_32_test: stimulus and verdict for the SuperFastHash engine
// Sends directed corner messages, then random messages with random idling on
// both queue ports, a long result stall and a full drain; a separate checker
// predicts and compares every hash.
// ============================================================================
module superfasthash_32_test;

   localparam int ITEM_TARGET  = 1000;
   localparam int STALL_LIMIT  = 3000;
   localparam int RSP_HOLD     = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int FLOOD_ITEMS  = 40;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [31:0] req_data_word;
   logic [2:0]  req_valid_bytes;
   logic [30:0] req_total_length;
   logic        req_last;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_hash_value;

   int fail_count;
   int expect_count;
   int items_sent;
   int msg_count;
   int quiet_cycles;
   bit rsp_hold_req;
   bit rsp_holding;

   superfasthash_32 dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_last         (req_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_hash_value   (rsp_hash_value)
   );

   superfasthash_32_check hash_check (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_last         (req_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_hash_value   (rsp_hash_value),
      .fail_count       (fail_count),
      .expect_count     (expect_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic [30:0] length, input logic last_flag);
      @(negedge clock);
      push             <= 1'b1;
      req_data_word    <= word;
      req_valid_bytes  <= nbytes;
      req_total_length <= length;
      req_last         <= last_flag;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_message(input int nbytes, input bit calm);
      int         words;
      int         rem;
      int         r;
      logic [30:0] seed;
      logic [2:0]  nb;
      seed  = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'(nbytes);
      words = nbytes / 4;
      rem   = nbytes % 4;
      if (rem == 0 && words > 0 && $urandom_range(0, 1) == 1) begin
         words--;
         rem = 4;
      end
      for (int i = 0; i < words; i++) begin
         nb = 3'd4;
         r  = $urandom_range(0, 19);
         if (r == 0) nb = 3'($urandom_range(5, 7));
         else if (r == 1) nb = 3'($urandom_range(0, 3));
         send_word($urandom, nb, (i == 0) ? seed : 31'($urandom), 1'b0);
         if (!calm) idle_gap(pick_gap());
      end
      nb = 3'(rem);
      if ($urandom_range(0, 19) == 0) nb = 3'($urandom_range(5, 7));
      send_word($urandom, nb, (words == 0) ? seed : 31'($urandom), 1'b1);
      if (!calm) idle_gap(pick_gap());
   endtask

   // receiver: random pop bursts and gaps, plus one long hold on request
   initial begin
      int gap;
      int burst;
      pop         = 1'b0;
      rsp_holding = 1'b0;
      forever begin
         if (rsp_hold_req) begin
            @(negedge clock);
            pop <= 1'b0;
            rsp_holding = 1'b1;
            repeat (RSP_HOLD) @(negedge clock);
            rsp_hold_req = 1'b0;
            rsp_holding  = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            @(negedge clock);
            pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                             : $urandom_range(1, 12);
         @(negedge clock);
         pop <= 1'b1;
         repeat (burst - 1) @(negedge clock);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t ERROR: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int r;
      int nbytes;
      reset            = 1'b1;
      push             = 1'b0;
      req_data_word    = '0;
      req_valid_bytes  = '0;
      req_total_length = '0;
      req_last         = 1'b0;
      rsp_hold_req     = 1'b0;
      items_sent       = 0;
      msg_count        = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty messages with zero and maximum seed, then single full-word messages
      send_word($urandom, 3'd0, 31'd0, 1'b1);
      send_word($urandom, 3'd0, 31'h7FFF_FFFF, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd4, 31'd4, 1'b1);
      send_word(32'h0000_0000, 3'd4, 31'd0, 1'b1);
      // tails of one, two and three bytes, sign bit set and clear
      send_word(($urandom & 32'hFFFF_FF00) | 32'h80, 3'd1, 31'd1, 1'b1);
      send_word(($urandom & 32'hFFFF_FF00) | 32'h7F, 3'd1, 31'd1, 1'b1);
      send_word(($urandom & 32'hFFFF_0000) | 32'hFFFF, 3'd2, 31'd2, 1'b1);
      send_word(32'hA580_7FFF, 3'd3, 31'd3, 1'b1);
      send_word(32'h5A7F_FFFF, 3'd3, 31'd3, 1'b1);
      // full word closed by an empty last transaction
      send_word($urandom, 3'd4, 31'd8, 1'b0);
      send_word($urandom, 3'd0, 31'd0, 1'b1);
      // oversized byte counts count as four
      send_word($urandom, 3'd5, 31'd12, 1'b0);
      send_word($urandom, 3'd6, 31'd0, 1'b0);
      send_word($urandom, 3'd7, 31'd0, 1'b1);
      // short words that are not last do no round
      send_word($urandom, 3'd2, 31'd7, 1'b0);
      send_word($urandom, 3'd0, 31'd5, 1'b0);
      send_word($urandom, 3'd3, 31'd0, 1'b1);
      // seed that does not match the bytes sent
      send_word($urandom, 3'd4, 31'd1000, 1'b0);
      send_word($urandom, 3'd4, 31'($urandom), 1'b0);
      send_word($urandom, 3'd1, 31'($urandom), 1'b1);
      idle_gap(3);

      while (items_sent < ITEM_TARGET) begin
         msg_count++;
         if (msg_count == 40) begin
            @(negedge clock);
            push <= 1'b0;
            rsp_hold_req = 1'b1;
            wait (rsp_holding);
            repeat (FLOOD_ITEMS)
               send_word($urandom, 3'($urandom_range(0, 4)), 31'($urandom), 1'b1);
         end
         if (msg_count == 110) begin
            @(negedge clock);
            push <= 1'b0;
            wait (expect_count == 0);
         end
         r      = $urandom_range(0, 99);
         nbytes = (r < 85) ? $urandom_range(0, 40) : $urandom_range(41, 300);
         send_message(nbytes, $urandom_range(0, 9) < 3);
      end

      @(negedge clock);
      push <= 1'b0;
      wait (expect_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
src/shf32_pkg.sv
src/shf32_fifo.sv
src/shf32_front.sv
src/shf32_back.sv
src/superfasthash_32.sv
dv/superfasthash_32_check.sv
dv/superfasthash_32_test.sv
